@@ hdl/ir_pointer_cursor_tracker_defines.svh @@
// Assertion macros shared by the assertions of the pointer cursor tracker checker.
// No dependencies; included by the checker file only.
`ifndef IR_POINTER_CURSOR_TRACKER_DEFINES_SVH
`define IR_POINTER_CURSOR_TRACKER_DEFINES_SVH

// Same-cycle implication, suspended while reset is high.
`define IPCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ir_pointer_cursor_tracker: same-cycle check failed");

// Next-cycle implication, suspended while reset is high.
`define IPCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ir_pointer_cursor_tracker: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define IPCT_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ir_pointer_cursor_tracker: reset check failed");

`endif

@@ hdl/ipct_pkg.sv @@
// Shared types, register indexes and reset values for the pointer cursor tracker.
// No dependencies; used by every module of the block.
package ipct_pkg;

   localparam int POS_W    = 16;
   localparam int SCREEN_W = 11;
   localparam int CSR_IDX_W = 3;

   localparam int EDGE_MARGIN_X_DEFAULT = 20;
   localparam int EDGE_MARGIN_Y_DEFAULT = 15;

   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 11'd640;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 11'd480;
   localparam logic [SCREEN_W-1:0] CENTER_X_RESET      = 11'd320;
   localparam logic [SCREEN_W-1:0] CENTER_Y_RESET      = 11'd240;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH   = 3'd0,
      CSR_SCREEN_HEIGHT  = 3'd1,
      CSR_CENTER_X       = 3'd2,
      CSR_CENTER_Y       = 3'd3,
      CSR_LOOK_MODE      = 3'd4,
      CSR_LOOK_INVERT    = 3'd5,
      CSR_KEYBOARD_SHOWN = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE   = 1'b0,
      OP_RECENTER = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      RUN_NONE = 2'd0,
      RUN_ONE  = 2'd1,
      RUN_MANY = 2'd2
   } run_type;

   typedef struct packed {
      logic [SCREEN_W-1:0] screen_width;
      logic [SCREEN_W-1:0] screen_height;
      logic [SCREEN_W-1:0] center_x;
      logic [SCREEN_W-1:0] center_y;
      logic                look_mode;
      logic                look_invert;
      logic                keyboard_shown;
   } cfg_type;

   typedef struct packed {
      logic                    operation;
      logic                    ir_valid;
      logic signed [POS_W-1:0] ir_x;
      logic signed [POS_W-1:0] ir_y;
      logic                    smooth_avail;
      logic signed [POS_W-1:0] smooth_x;
      logic signed [POS_W-1:0] smooth_y;
   } item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] current_x;
      logic signed [POS_W-1:0] current_y;
      logic signed [POS_W-1:0] previous_x;
      logic signed [POS_W-1:0] previous_y;
      logic [1:0]              valid_run;
      logic signed [POS_W-1:0] offset_x;
      logic signed [POS_W-1:0] offset_y;
   } state_type;

   typedef struct packed {
      logic                    cursor_enabled;
      logic signed [POS_W-1:0] cursor_x;
      logic signed [POS_W-1:0] cursor_y;
   } result_type;

endpackage

@@ hdl/ipct_csr.sv @@
// Configuration register file of the pointer cursor tracker.
// Depends on ipct_pkg for the register indexes, reset values and cfg_type.
module ipct_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [ipct_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ipct_pkg::SCREEN_W-1:0]        csr_write_data,
   output ipct_pkg::cfg_type                    cfg
);

   ipct_pkg::cfg_type cfg_ff;
   ipct_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ipct_pkg::CSR_SCREEN_WIDTH:   cfg_in.screen_width   = csr_write_data;
            ipct_pkg::CSR_SCREEN_HEIGHT:  cfg_in.screen_height  = csr_write_data;
            ipct_pkg::CSR_CENTER_X:       cfg_in.center_x       = csr_write_data;
            ipct_pkg::CSR_CENTER_Y:       cfg_in.center_y       = csr_write_data;
            ipct_pkg::CSR_LOOK_MODE:      cfg_in.look_mode      = csr_write_data[0];
            ipct_pkg::CSR_LOOK_INVERT:    cfg_in.look_invert    = csr_write_data[0];
            ipct_pkg::CSR_KEYBOARD_SHOWN: cfg_in.keyboard_shown = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width   <= ipct_pkg::SCREEN_WIDTH_RESET;
         cfg_ff.screen_height  <= ipct_pkg::SCREEN_HEIGHT_RESET;
         cfg_ff.center_x       <= ipct_pkg::CENTER_X_RESET;
         cfg_ff.center_y       <= ipct_pkg::CENTER_Y_RESET;
         cfg_ff.look_mode      <= 1'b0;
         cfg_ff.look_invert    <= 1'b0;
         cfg_ff.keyboard_shown <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/ipct_core.sv @@
// Combinational step of the pointer cursor tracker: next tracking state and result word.
// Depends on ipct_pkg for cfg_type, item_type, state_type and result_type.
module ipct_core #(
   parameter int EDGE_MARGIN_X = ipct_pkg::EDGE_MARGIN_X_DEFAULT,
   parameter int EDGE_MARGIN_Y = ipct_pkg::EDGE_MARGIN_Y_DEFAULT
) (
   input  ipct_pkg::cfg_type    cfg,
   input  ipct_pkg::item_type   item,
   input  ipct_pkg::state_type  state,
   output ipct_pkg::state_type  state_next,
   output ipct_pkg::result_type result
);

   localparam int WW = ipct_pkg::POS_W + 2;

   // Clamp to the signed 16-bit range.
   function automatic logic signed [ipct_pkg::POS_W-1:0] sat16(input logic signed [WW-1:0] v);
      logic signed [ipct_pkg::POS_W-1:0] r;
      if (v > WW'(32767))        r = 16'sh7fff;
      else if (v < -WW'(32768))  r = 16'sh8000;
      else                       r = v[ipct_pkg::POS_W-1:0];
      return r;
   endfunction

   logic signed [WW-1:0] mx, my, wid, hei, cur_x, cur_y;
   logic signed [WW-1:0] dl, dr, dt, db, dh, dv;
   logic signed [ipct_pkg::POS_W-1:0] ex, ey, snap_x, snap_y;
   logic left, top, horiz, in_screen, snap;
   logic enabled;

   assign mx    = WW'(EDGE_MARGIN_X);
   assign my    = WW'(EDGE_MARGIN_Y);
   assign wid   = signed'({{(WW-ipct_pkg::SCREEN_W){1'b0}}, cfg.screen_width});
   assign hei   = signed'({{(WW-ipct_pkg::SCREEN_W){1'b0}}, cfg.screen_height});
   assign cur_x = WW'(state.current_x);
   assign cur_y = WW'(state.current_y);

   // Linear extrapolation from the last two positions.
   assign ex = sat16((cur_x <<< 1) - WW'(state.previous_x));
   assign ey = sat16((cur_y <<< 1) - WW'(state.previous_y));
   assign in_screen = (ex > 16'sd0) && (ey > 16'sd0)
                      && (WW'(ex) < wid) && (WW'(ey) < hei);

   // Edge distances; ties go right, bottom, then vertical.
   assign dl    = cur_x;
   assign dr    = wid - WW'(1) - cur_x;
   assign dt    = cur_y;
   assign db    = hei - WW'(1) - cur_y;
   assign left  = dl < dr;
   assign top   = dt < db;
   assign dh    = left ? dl : dr;
   assign dv    = top ? dt : db;
   assign horiz = dh < dv;

   // Overshoot past the edge inside the margin, else pin to it.
   always_comb begin
      if (left) snap_x = (dl < mx) ? sat16(cur_x - mx) : 16'sd0;
      else      snap_x = (dr < mx) ? sat16(cur_x + mx) : sat16(wid - WW'(1));
      if (top)  snap_y = (dt < my) ? sat16(cur_y - my) : 16'sd0;
      else      snap_y = (db < my) ? sat16(cur_y + my) : sat16(hei - WW'(1));
   end

   always_comb begin
      unique case (state.valid_run)
         ipct_pkg::RUN_NONE: snap = 1'b0;
         ipct_pkg::RUN_ONE:  snap = 1'b1;
         default:            snap = in_screen;
      endcase
   end

   always_comb begin
      state_next = state;
      if (item.operation == ipct_pkg::OP_RECENTER) begin
         state_next.offset_x = sat16(cur_x - WW'(cfg.center_x));
         state_next.offset_y = sat16(cur_y - WW'(cfg.center_y));
      end else if (item.ir_valid) begin
         state_next.previous_x = state.current_x;
         state_next.previous_y = state.current_y;
         state_next.current_x  = item.ir_x;
         state_next.current_y  = item.ir_y;
         if (state.valid_run == ipct_pkg::RUN_NONE) begin
            state_next.offset_x = sat16(WW'(item.ir_x) - WW'(cfg.center_x));
            state_next.offset_y = sat16(WW'(item.ir_y) - WW'(cfg.center_y));
         end
         if (state.valid_run == ipct_pkg::RUN_NONE) state_next.valid_run = ipct_pkg::RUN_ONE;
         else                                       state_next.valid_run = ipct_pkg::RUN_MANY;
      end else begin
         state_next.previous_x = state.current_x;
         state_next.previous_y = state.current_y;
         state_next.valid_run  = ipct_pkg::RUN_NONE;
         if (!snap) begin
            state_next.current_x = ex;
            state_next.current_y = ey;
         end else if (item.smooth_avail) begin
            state_next.current_x = item.smooth_x;
            state_next.current_y = item.smooth_y;
         end else if (horiz) begin
            state_next.current_x = snap_x;
         end else begin
            state_next.current_y = snap_y;
         end
      end
   end

   assign enabled = (cfg.look_mode != cfg.look_invert) && !cfg.keyboard_shown;

   always_comb begin
      result.cursor_enabled = enabled;
      result.cursor_x = 16'sd0;
      result.cursor_y = 16'sd0;
      if (enabled) begin
         result.cursor_x = sat16(WW'(state_next.current_x) - WW'(state_next.offset_x));
         result.cursor_y = sat16(WW'(state_next.current_y) - WW'(state_next.offset_y));
      end
   end

endmodule

@@ hdl/ir_pointer_cursor_tracker.sv @@
// Pointer cursor tracker: one result word for every accepted request word.
// Each accepted request word passes through the input register, then the result register,
// where it raises rsp_valid. Throughput: one word per cycle while rsp_stall is low; the single-pass step allows it.
// Reset (synchronous, active high): empties both registers, clears the tracking state to zero,
// and loads the configuration reset values (640 x 480 screen, center 320,240, look gating off).
module ir_pointer_cursor_tracker #(
   parameter int EDGE_MARGIN_X = ipct_pkg::EDGE_MARGIN_X_DEFAULT,
   parameter int EDGE_MARGIN_Y = ipct_pkg::EDGE_MARGIN_Y_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration write port
   input  logic                                 csr_write_enable,
   input  logic [ipct_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ipct_pkg::SCREEN_W-1:0]        csr_write_data,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic                                 req_ir_valid,
   input  logic signed [ipct_pkg::POS_W-1:0]    req_ir_x,
   input  logic signed [ipct_pkg::POS_W-1:0]    req_ir_y,
   input  logic                                 req_smooth_avail,
   input  logic signed [ipct_pkg::POS_W-1:0]    req_smooth_x,
   input  logic signed [ipct_pkg::POS_W-1:0]    req_smooth_y,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_cursor_enabled,
   output logic signed [ipct_pkg::POS_W-1:0]    rsp_cursor_x,
   output logic signed [ipct_pkg::POS_W-1:0]    rsp_cursor_y
);

   ipct_pkg::cfg_type    cfg;
   ipct_pkg::item_type   req_item;
   ipct_pkg::state_type  state_next;
   ipct_pkg::result_type result;

   // Input register: holds the word being worked on.
   logic                 in_valid_ff, in_valid_in;
   ipct_pkg::item_type   in_item_ff;
   // Result register: holds the finished word until the consumer takes it.
   logic                 out_valid_ff, out_valid_in;
   ipct_pkg::result_type out_result_ff;
   // Tracking state: position, previous position, valid run and offset.
   ipct_pkg::state_type  state_ff;

   logic advance;  // result register can take a new word this cycle
   logic fire;     // input word commits its state update and result

   ipct_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ipct_core #(
      .EDGE_MARGIN_X (EDGE_MARGIN_X),
      .EDGE_MARGIN_Y (EDGE_MARGIN_Y)
   ) u_core (
      .cfg        (cfg),
      .item       (in_item_ff),
      .state      (state_ff),
      .state_next (state_next),
      .result     (result)
   );

   assign req_item.operation    = req_operation;
   assign req_item.ir_valid     = req_ir_valid;
   assign req_item.ir_x         = req_ir_x;
   assign req_item.ir_y         = req_ir_y;
   assign req_item.smooth_avail = req_smooth_avail;
   assign req_item.smooth_x     = req_smooth_x;
   assign req_item.smooth_y     = req_smooth_y;

   // Advance whenever the result slot is empty or being drained; stall the
   // requester only if the held word cannot move forward.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) in_valid_in = req_valid;
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = in_valid_ff;
   end

   // Control and tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) state_ff <= state_next;
      end
   end

   // Payload registers: load on acceptance, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_item_ff <= req_item;
      if (fire) out_result_ff <= result;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_cursor_enabled = out_result_ff.cursor_enabled;
   assign rsp_cursor_x       = out_result_ff.cursor_x;
   assign rsp_cursor_y       = out_result_ff.cursor_y;

endmodule

@@ hdl/ipct_checker.sv @@
// Port-level checker for the pointer cursor tracker, bound to the top level.
// Depends on ipct_pkg and on the macros in ir_pointer_cursor_tracker_defines.svh.
`include "ir_pointer_cursor_tracker_defines.svh"

module ipct_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_cursor_enabled,
   input logic signed [ipct_pkg::POS_W-1:0]  rsp_cursor_x,
   input logic signed [ipct_pkg::POS_W-1:0]  rsp_cursor_y
);

   // A stalled result word stays and holds its payload.
   `IPCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_cursor_enabled) && $stable(rsp_cursor_x) && $stable(rsp_cursor_y))

   // With the result slot empty the block never stalls the requester.
   `IPCT_ASSERT_NOW(a_no_idle_stall, clock, reset, !rsp_valid, !req_stall)

   // A gated-off cursor reports the origin.
   `IPCT_ASSERT_NOW(a_gated_zero, clock, reset, rsp_valid && !rsp_cursor_enabled,
      rsp_cursor_x == 16'sd0 && rsp_cursor_y == 16'sd0)

   // Reset empties the pipeline.
   `IPCT_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind ir_pointer_cursor_tracker ipct_checker u_ipct_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking bench for the IR pointer cursor tracker: it predicts every result word
// and compares it field by field. Depends on ipct_pkg and ir_pointer_cursor_tracker only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Margins match the defaults the block is built with below.
   localparam int MARGIN_X      = ipct_pkg::EDGE_MARGIN_X_DEFAULT;
   localparam int MARGIN_Y      = ipct_pkg::EDGE_MARGIN_Y_DEFAULT;
   // Request register plus result register, with some slack.
   localparam int DRAIN_CYCLES  = 6;
   // No legal run goes this long without moving a word or writing a register.
   localparam int WATCHDOG_MAX  = 3000;
   localparam int REPORT_MAX    = 30;

   logic                                clock;
   logic                                reset;
   logic                                csr_write_enable;
   logic [ipct_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [ipct_pkg::SCREEN_W-1:0]       csr_write_data;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_operation;
   logic                                req_ir_valid;
   logic signed [ipct_pkg::POS_W-1:0]   req_ir_x;
   logic signed [ipct_pkg::POS_W-1:0]   req_ir_y;
   logic                                req_smooth_avail;
   logic signed [ipct_pkg::POS_W-1:0]   req_smooth_x;
   logic signed [ipct_pkg::POS_W-1:0]   req_smooth_y;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic                                rsp_cursor_enabled;
   logic signed [ipct_pkg::POS_W-1:0]   rsp_cursor_x;
   logic signed [ipct_pkg::POS_W-1:0]   rsp_cursor_y;

   ir_pointer_cursor_tracker u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_ir_valid       (req_ir_valid),
      .req_ir_x           (req_ir_x),
      .req_ir_y           (req_ir_y),
      .req_smooth_avail   (req_smooth_avail),
      .req_smooth_x       (req_smooth_x),
      .req_smooth_y       (req_smooth_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cursor_enabled (rsp_cursor_enabled),
      .rsp_cursor_x       (rsp_cursor_x),
      .rsp_cursor_y       (rsp_cursor_y)
   );

   // ------------------------------------------------------------------
   // Tracker state mirrored by the bench, plus the register settings.
   // Positions are kept as int, always inside the signed 16-bit range.
   // ------------------------------------------------------------------
   ipct_pkg::cfg_type    trk_cfg;
   int                   trk_cur_x, trk_cur_y;
   int                   trk_prev_x, trk_prev_y;
   int                   trk_off_x, trk_off_y;
   ipct_pkg::run_type    trk_run;

   ipct_pkg::result_type pending_cursor_q[$];

   int         send_idle_pct;
   int         recv_idle_pct;
   int         hold_left;
   int         req_words;
   int         rsp_words;
   int         csr_writes;
   int         fail_count;
   int         idle_cycles;

   // ------------------------------------------------------------------
   // Clock and receiver stall
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Drive the result stall on the falling edge. A pending hold-off wins over
   // the random stall and is counted down here by one at each falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic void recenter_offset();
      trk_off_x = clamp16(trk_cur_x - int'(trk_cfg.center_x));
      trk_off_y = clamp16(trk_cur_y - int'(trk_cfg.center_y));
   endfunction

   // Lost pointer with a short run or an on-screen extrapolation: take the
   // smoothed position if there is one, else push toward the nearest edge.
   function automatic void snap_to_edge(bit sm_v, int sm_x, int sm_y);
      int w;
      int h;
      int dl;
      int dr;
      int dt;
      int db;
      int dh;
      int dv;
      bit is_left;
      bit is_top;
      w = int'(trk_cfg.screen_width);
      h = int'(trk_cfg.screen_height);
      trk_prev_x = trk_cur_x;
      trk_prev_y = trk_cur_y;
      if (sm_v) begin
         trk_cur_x = sm_x;
         trk_cur_y = sm_y;
         return;
      end
      dl = trk_cur_x;
      dr = w - 1 - trk_cur_x;
      dt = trk_cur_y;
      db = h - 1 - trk_cur_y;
      // Ties go right, bottom, and vertical.
      is_left = dl < dr;
      is_top  = dt < db;
      dh = is_left ? dl : dr;
      dv = is_top ? dt : db;
      if (dh < dv) begin
         if (is_left)
            trk_cur_x = (dl < MARGIN_X) ? dl - MARGIN_X : 0;
         else
            trk_cur_x = (dr < MARGIN_X) ? w - 1 + MARGIN_X - dr : w - 1;
         trk_cur_x = clamp16(trk_cur_x);
      end else begin
         if (is_top)
            trk_cur_y = (dt < MARGIN_Y) ? dt - MARGIN_Y : 0;
         else
            trk_cur_y = (db < MARGIN_Y) ? h - 1 + MARGIN_Y - db : h - 1;
         trk_cur_y = clamp16(trk_cur_y);
      end
   endfunction

   // Advance the mirrored state by one request word and return its result.
   function automatic ipct_pkg::result_type predict_cursor(ipct_pkg::item_type it);
      ipct_pkg::result_type r;
      int ex;
      int ey;
      bit snap;
      bit enabled;
      if (it.operation == ipct_pkg::OP_RECENTER) begin
         recenter_offset();
      end else if (it.ir_valid) begin
         trk_prev_x = trk_cur_x;
         trk_prev_y = trk_cur_y;
         trk_cur_x  = int'($signed(it.ir_x));
         trk_cur_y  = int'($signed(it.ir_y));
         // First sight after a loss re-anchors the offset.
         if (trk_run == ipct_pkg::RUN_NONE) begin
            recenter_offset();
            trk_run = ipct_pkg::RUN_ONE;
         end else begin
            trk_run = ipct_pkg::RUN_MANY;
         end
      end else begin
         ex = clamp16(2 * trk_cur_x - trk_prev_x);
         ey = clamp16(2 * trk_cur_y - trk_prev_y);
         case (trk_run)
            ipct_pkg::RUN_NONE: snap = 1'b0;
            ipct_pkg::RUN_ONE:  snap = 1'b1;
            default:  snap = ex > 0 && ey > 0 && ex < int'(trk_cfg.screen_width)
                             && ey < int'(trk_cfg.screen_height);
         endcase
         if (snap) begin
            snap_to_edge(it.smooth_avail, int'($signed(it.smooth_x)),
                         int'($signed(it.smooth_y)));
         end else begin
            trk_prev_x = trk_cur_x;
            trk_prev_y = trk_cur_y;
            trk_cur_x  = ex;
            trk_cur_y  = ey;
         end
         trk_run = ipct_pkg::RUN_NONE;
      end
      enabled = (trk_cfg.look_mode != trk_cfg.look_invert) && !trk_cfg.keyboard_shown;
      r.cursor_enabled = enabled;
      r.cursor_x = enabled ? ipct_pkg::POS_W'(clamp16(trk_cur_x - trk_off_x)) : '0;
      r.cursor_y = enabled ? ipct_pkg::POS_W'(clamp16(trk_cur_y - trk_off_y)) : '0;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result checking: every accepted result word against the oldest
   // prediction. Sample on the rising edge, before the block updates.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      ipct_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_words = rsp_words + 1;
         if (pending_cursor_q.size() == 0) begin
            fail_count = fail_count + 1;
            if (fail_count <= REPORT_MAX)
               $display("%0t: result word with nothing pending: en=%0b x=%0d y=%0d",
                        $time, rsp_cursor_enabled, rsp_cursor_x, rsp_cursor_y);
         end else begin
            want = pending_cursor_q.pop_front();
            if (rsp_cursor_enabled !== want.cursor_enabled) begin
               fail_count = fail_count + 1;
               if (fail_count <= REPORT_MAX)
                  $display("%0t: cursor_enabled expected %0b got %0b",
                           $time, want.cursor_enabled, rsp_cursor_enabled);
            end
            if (rsp_cursor_x !== want.cursor_x) begin
               fail_count = fail_count + 1;
               if (fail_count <= REPORT_MAX)
                  $display("%0t: cursor_x expected %0d got %0d",
                           $time, want.cursor_x, rsp_cursor_x);
            end
            if (rsp_cursor_y !== want.cursor_y) begin
               fail_count = fail_count + 1;
               if (fail_count <= REPORT_MAX)
                  $display("%0t: cursor_y expected %0d got %0d",
                           $time, want.cursor_y, rsp_cursor_y);
            end
         end
      end
   end

   // Watchdog: count cycles in which no word moves and no register is written.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || csr_write_enable) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: watchdog expired, %0d results still pending",
                     $time, pending_cursor_q.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Driving helpers
   // ------------------------------------------------------------------

   // Offer one request word on the falling edge and hold it until accepted.
   // Valid stays high afterwards; the next call replaces the word or, while idling, lowers it, and end_burst lowers it.
   task automatic send_word(ipct_pkg::item_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_operation    = it.operation;
      req_ir_valid     = it.ir_valid;
      req_ir_x         = it.ir_x;
      req_ir_y         = it.ir_y;
      req_smooth_avail = it.smooth_avail;
      req_smooth_x     = it.smooth_x;
      req_smooth_y     = it.smooth_y;
      req_valid        = 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      req_words = req_words + 1;
      pending_cursor_q.push_back(predict_cursor(it));
   endtask

   // Drop valid, then wait for every pending result plus the pipeline depth.
   task automatic end_burst();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_cursor_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_sample(int x, int y);
      ipct_pkg::item_type it;
      it.operation    = ipct_pkg::OP_SAMPLE;
      it.ir_valid     = 1'b1;
      it.ir_x         = ipct_pkg::POS_W'(x);
      it.ir_y         = ipct_pkg::POS_W'(y);
      it.smooth_avail = 1'($urandom_range(1));
      it.smooth_x     = ipct_pkg::POS_W'($urandom);
      it.smooth_y     = ipct_pkg::POS_W'($urandom);
      send_word(it);
   endtask

   task automatic send_loss(bit sm_v, int sx, int sy);
      ipct_pkg::item_type it;
      it.operation    = ipct_pkg::OP_SAMPLE;
      it.ir_valid     = 1'b0;
      it.ir_x         = ipct_pkg::POS_W'($urandom);
      it.ir_y         = ipct_pkg::POS_W'($urandom);
      it.smooth_avail = sm_v;
      it.smooth_x     = ipct_pkg::POS_W'(sx);
      it.smooth_y     = ipct_pkg::POS_W'(sy);
      send_word(it);
   endtask

   task automatic send_recenter();
      ipct_pkg::item_type it;
      it.operation    = ipct_pkg::OP_RECENTER;
      it.ir_valid     = 1'($urandom_range(1));
      it.ir_x         = ipct_pkg::POS_W'($urandom);
      it.ir_y         = ipct_pkg::POS_W'($urandom);
      it.smooth_avail = 1'($urandom_range(1));
      it.smooth_x     = ipct_pkg::POS_W'($urandom);
      it.smooth_y     = ipct_pkg::POS_W'($urandom);
      send_word(it);
   endtask

   task automatic csr_write(ipct_pkg::csr_index_type idx,
                            logic [ipct_pkg::SCREEN_W-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      case (idx)
         ipct_pkg::CSR_SCREEN_WIDTH:   trk_cfg.screen_width   = value;
         ipct_pkg::CSR_SCREEN_HEIGHT:  trk_cfg.screen_height  = value;
         ipct_pkg::CSR_CENTER_X:       trk_cfg.center_x       = value;
         ipct_pkg::CSR_CENTER_Y:       trk_cfg.center_y       = value;
         ipct_pkg::CSR_LOOK_MODE:      trk_cfg.look_mode      = value[0];
         ipct_pkg::CSR_LOOK_INVERT:    trk_cfg.look_invert    = value[0];
         ipct_pkg::CSR_KEYBOARD_SHOWN: trk_cfg.keyboard_shown = value[0];
         default: ;
      endcase
      csr_writes = csr_writes + 1;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Only call while idle: after end_burst.
   task automatic apply_config(ipct_pkg::cfg_type c);
      csr_write(ipct_pkg::CSR_SCREEN_WIDTH,   c.screen_width);
      csr_write(ipct_pkg::CSR_SCREEN_HEIGHT,  c.screen_height);
      csr_write(ipct_pkg::CSR_CENTER_X,       c.center_x);
      csr_write(ipct_pkg::CSR_CENTER_Y,       c.center_y);
      csr_write(ipct_pkg::CSR_LOOK_MODE,      ipct_pkg::SCREEN_W'(c.look_mode));
      csr_write(ipct_pkg::CSR_LOOK_INVERT,    ipct_pkg::SCREEN_W'(c.look_invert));
      csr_write(ipct_pkg::CSR_KEYBOARD_SHOWN, ipct_pkg::SCREEN_W'(c.keyboard_shown));
   endtask

   function automatic ipct_pkg::cfg_type make_cfg(int w, int h, int cx, int cy,
                                                  bit mode, bit inv, bit kb);
      ipct_pkg::cfg_type c;
      c.screen_width   = ipct_pkg::SCREEN_W'(w);
      c.screen_height  = ipct_pkg::SCREEN_W'(h);
      c.center_x       = ipct_pkg::SCREEN_W'(cx);
      c.center_y       = ipct_pkg::SCREEN_W'(cy);
      c.look_mode      = mode;
      c.look_invert    = inv;
      c.keyboard_shown = kb;
      return c;
   endfunction

   // A coordinate for a screen dimension: mostly on screen, a good share hugging
   // either edge, some just off screen and a few anywhere in 16 bits.
   function automatic int pick_coord(int span);
      int s;
      int roll;
      logic signed [ipct_pkg::POS_W-1:0] wide;
      s    = (span < 1) ? 1 : span;
      roll = $urandom_range(99);
      wide = ipct_pkg::POS_W'($urandom);
      if (roll < 55) return int'($urandom_range(s - 1));
      if (roll < 75) begin
         if ($urandom_range(1)) return int'($urandom_range(30)) - 5;
         return s + 4 - int'($urandom_range(30));
      end
      if (roll < 90) return int'($urandom_range(s + 80)) - 40;
      return int'(wide);
   endfunction

   // Mostly well-formed tracking: a run of sightings that drift, then a short
   // loss, now and then a recenter, plus some words of pure noise.
   task automatic drive_tracking(int count);
      int sent;
      int burst;
      int k;
      int w;
      int h;
      int x;
      int y;
      ipct_pkg::item_type noise;
      sent = 0;
      while (sent < count) begin
         w = int'(trk_cfg.screen_width);
         h = int'(trk_cfg.screen_height);
         if ($urandom_range(99) < 8) begin
            noise.operation    = 1'($urandom_range(1));
            noise.ir_valid     = 1'($urandom_range(1));
            noise.ir_x         = ipct_pkg::POS_W'($urandom);
            noise.ir_y         = ipct_pkg::POS_W'($urandom);
            noise.smooth_avail = 1'($urandom_range(1));
            noise.smooth_x     = ipct_pkg::POS_W'($urandom);
            noise.smooth_y     = ipct_pkg::POS_W'($urandom);
            send_word(noise);
            sent = sent + 1;
         end else if ($urandom_range(99) < 7) begin
            send_recenter();
            sent = sent + 1;
         end else begin
            burst = $urandom_range(6, 1);
            x = pick_coord(w);
            y = pick_coord(h);
            for (k = 0; k < burst && sent < count; k++) begin
               send_sample(x, y);
               sent = sent + 1;
               if ($urandom_range(99) < 70) begin
                  x = x + int'($urandom_range(60)) - 30;
                  y = y + int'($urandom_range(60)) - 30;
               end else begin
                  x = pick_coord(w);
                  y = pick_coord(h);
               end
            end
            burst = $urandom_range(4, 1);
            for (k = 0; k < burst && sent < count; k++) begin
               send_loss($urandom_range(99) < 30, pick_coord(w), pick_coord(h));
               sent = sent + 1;
            end
         end
      end
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings leave look gating off: positions must come out as zero.
   task automatic test_reset_gating();
      send_sample(123, 45);
      send_loss(1'b0, 0, 0);
      send_recenter();
      end_burst();
   endtask

   // Hand-picked words on the default screen with output enabled.
   task automatic test_directed_cases();
      csr_write(ipct_pkg::CSR_LOOK_MODE, ipct_pkg::SCREEN_W'(1));
      send_loss(1'b0, 0, 0);                 // loss with no valid run: extrapolate
      send_sample(100, 50);                  // first sight: offset re-anchored
      send_sample(110, 60);
      send_loss(1'b0, 0, 0);                 // on-screen extrapolation: pin to top
      send_recenter();
      send_sample(5, 200);
      send_loss(1'b0, 0, 0);                 // short run: overshoot left edge
      send_loss(1'b0, 0, 0);                 // second loss: extrapolate
      send_sample(630, 470);
      send_loss(1'b0, 0, 0);                 // corner tie: bottom edge wins
      send_sample(300, 200);
      send_sample(310, 205);
      send_loss(1'b1, -32768, 32767);        // snap replaced by smoothed position
      send_sample(-32768, -32768);           // offset saturates
      send_sample(32767, 32767);             // output difference saturates
      send_loss(1'b0, 0, 0);                 // extrapolation saturates, off screen
      send_sample(0, 0);
      send_sample(0, 0);
      send_loss(1'b0, 0, 0);                 // zero is not strictly inside
      send_recenter();
      send_sample(630, 240);
      send_sample(630, 240);
      send_loss(1'b0, 0, 0);                 // overshoot right edge
      end_burst();
   endtask

   // Walk the registers through their extremes, each with a short tracking burst.
   task automatic test_config_extremes();
      ipct_pkg::cfg_type corner[6];
      int i;
      corner[0] = make_cfg(1, 1, 0, 0, 1'b0, 1'b1, 1'b0);
      corner[1] = make_cfg(2047, 2047, 2047, 2047, 1'b1, 1'b0, 1'b0);
      corner[2] = make_cfg(0, 0, 1023, 5, 1'b1, 1'b0, 1'b0);
      corner[3] = make_cfg(41, 31, 20, 15, 1'b1, 1'b0, 1'b0);
      corner[4] = make_cfg(2047, 1, 0, 2047, 1'b1, 1'b1, 1'b0);
      corner[5] = make_cfg(640, 480, 320, 240, 1'b0, 1'b1, 1'b1);
      for (i = 0; i < 6; i++) begin
         apply_config(corner[i]);
         drive_tracking(35);
         end_burst();
      end
   endtask

   // Hold the result side off for a long stretch while words keep coming, so the
   // block fills and stalls its request side.
   task automatic test_stall_backpressure();
      apply_config(make_cfg(320, 200, 160, 100, 1'b1, 1'b0, 1'b0));
      @(posedge clock);
      hold_left = 80;
      drive_tracking(30);
      end_burst();
   endtask

   // Long random tracking, with a fresh random screen every third of the run.
   task automatic test_random_tracking(int count);
      int part;
      bit mode;
      ipct_pkg::cfg_type c;
      for (part = 0; part < 3; part++) begin
         mode = 1'($urandom_range(1));
         c = make_cfg($urandom_range(1024, 8), $urandom_range(768, 8),
                      $urandom_range(1024), $urandom_range(768),
                      mode, ($urandom_range(99) < 80) ? !mode : mode,
                      $urandom_range(99) < 10);
         apply_config(c);
         drive_tracking(count / 3);
         end_burst();
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_operation    = ipct_pkg::OP_SAMPLE;
      req_ir_valid     = 1'b0;
      req_ir_x         = '0;
      req_ir_y         = '0;
      req_smooth_avail = 1'b0;
      req_smooth_x     = '0;
      req_smooth_y     = '0;
      hold_left        = 0;
      req_words        = 0;
      rsp_words        = 0;
      csr_writes       = 0;
      fail_count       = 0;
      idle_cycles      = 0;
      set_idling(0, 0);

      // Mirror the reset state of the block.
      trk_cfg = make_cfg(ipct_pkg::SCREEN_WIDTH_RESET, ipct_pkg::SCREEN_HEIGHT_RESET,
                         ipct_pkg::CENTER_X_RESET, ipct_pkg::CENTER_Y_RESET,
                         1'b0, 1'b0, 1'b0);
      trk_cur_x  = 0;
      trk_cur_y  = 0;
      trk_prev_x = 0;
      trk_prev_y = 0;
      trk_off_x  = 0;
      trk_off_y  = 0;
      trk_run    = ipct_pkg::RUN_NONE;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_idling(33, 73);
      test_reset_gating();
      test_directed_cases();
      test_random_tracking(270);

      set_idling(73, 33);
      test_config_extremes();
      test_random_tracking(240);

      set_idling(0, 0);
      test_stall_backpressure();
      test_random_tracking(270);

      $display("covered %0d request words and %0d result words over %0d register writes,",
               req_words, rsp_words, csr_writes);
      $display("including register extremes, three idling mixes and a long result hold-off");
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d field mismatches or stray results", fail_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
